### hw/rtl/cprsm_pkg.sv
// ============================================================================
// cprsm_pkg: shared types and constants of the contact pulse rate speed meter
// Holds the register index codes, the reset values of the configuration
// registers, the divide job format and the divider state encoding.
// ============================================================================
package cprsm_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 2;

    // Register index codes of the configuration port.
    localparam logic [INDEX_W-1:0] REG_EDGE_STEP    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WINDOW_TICKS = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SUM_LIMIT    = 2'd2;

    // Values the configuration registers take at reset.
    localparam logic [DATA_W-1:0] EDGE_STEP_RESET    = 32'd3125000;
    localparam logic [DATA_W-1:0] WINDOW_TICKS_RESET = 32'd500000;
    localparam logic [DATA_W-1:0] SUM_LIMIT_RESET    = 32'd4291842295;

    // Depth of the queue between the front and the divider.
    localparam int unsigned JOB_DEPTH = 2;

    // Number of restoring division steps: the numerator is 33 bits wide.
    localparam int unsigned DIV_STEPS = DATA_W + 1;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [DATA_W-1:0] edge_step;
        logic [DATA_W-1:0] window_ticks;
        logic [DATA_W-1:0] sum_limit;
    } cfg_t;

    // One closed window waiting to be divided.
    typedef struct packed {
        logic [DATA_W-1:0] pulse_sum;
        logic [DATA_W-1:0] elapsed_ticks;
    } job_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

### hw/rtl/cprsm_front.sv
// ============================================================================
// cprsm_front: sample tracking and window accumulation
// Detects falling contact edges, runs the measurement window and hands a
// divide job to the queue on the sample that closes a window.
// ============================================================================
module cprsm_front #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic [TIMER_BITS-1:0]  timer_value,
    input  logic                   contact_level,
    input  cprsm_pkg::cfg_t        cfg,
    output logic                   job_valid,
    output cprsm_pkg::job_t        job
);

    localparam int unsigned DW = cprsm_pkg::DATA_W;

    logic                  last_level_reg, last_level_next;
    logic [TIMER_BITS-1:0] last_timer_reg, last_timer_next;
    logic                  measuring_reg, measuring_next;
    logic [DW-1:0]         pulse_sum_reg, pulse_sum_next;
    logic [DW-1:0]         elapsed_reg, elapsed_next;

    logic                  fell;
    logic [TIMER_BITS-1:0] delta;
    logic [DW:0]           elapsed_wide;
    logic [DW-1:0]         elapsed_sat;
    logic [DW:0]           sum_wide;
    logic [DW-1:0]         sum_sat;
    logic                  sum_close;
    logic                  time_close;
    logic                  close;

    always_comb
    begin
        fell         = last_level_reg & ~contact_level;
        delta        = timer_value - last_timer_reg;
        elapsed_wide = {1'b0, elapsed_reg} + {{(DW + 1 - TIMER_BITS){1'b0}}, delta};
        elapsed_sat  = elapsed_wide[DW] ? {DW{1'b1}} : elapsed_wide[DW-1:0];
        sum_wide     = {1'b0, pulse_sum_reg} + {1'b0, cfg.edge_step};
        sum_sat      = sum_wide[DW] ? {DW{1'b1}} : sum_wide[DW-1:0];
        sum_close    = fell & (sum_sat >= cfg.sum_limit);
        time_close   = elapsed_sat > cfg.window_ticks;
        close        = measuring_reg & (sum_close | time_close);
    end

    always_comb
    begin
        last_level_next = last_level_reg;
        last_timer_next = last_timer_reg;
        measuring_next  = measuring_reg;
        pulse_sum_next  = pulse_sum_reg;
        elapsed_next    = elapsed_reg;
        if (sample_valid)
        begin
            last_level_next = contact_level;
            if (!measuring_reg)
            begin
                if (fell)
                begin
                    measuring_next  = 1'b1;
                    pulse_sum_next  = '0;
                    elapsed_next    = '0;
                    last_timer_next = timer_value;
                end
            end
            else
            begin
                last_timer_next = timer_value;
                elapsed_next    = elapsed_sat;
                if (fell)
                begin
                    pulse_sum_next = sum_sat;
                end
                if (close)
                begin
                    measuring_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            last_timer_reg <= '0;
            measuring_reg  <= 1'b0;
            pulse_sum_reg  <= '0;
            elapsed_reg    <= '0;
        end
        else
        begin
            last_level_reg <= last_level_next;
            last_timer_reg <= last_timer_next;
            measuring_reg  <= measuring_next;
            pulse_sum_reg  <= pulse_sum_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    assign job_valid         = sample_valid & close;
    assign job.pulse_sum     = fell ? sum_sat : pulse_sum_reg;
    assign job.elapsed_ticks = elapsed_sat;

endmodule

### hw/rtl/cprsm_job_queue.sv
// ============================================================================
// cprsm_job_queue: short queue of divide jobs
// Decouples the sample front from the iterative divider.
// ============================================================================
module cprsm_job_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cprsm_pkg::job_t wr_job,
    input  logic            rd_en,
    output logic            rd_valid,
    output cprsm_pkg::job_t rd_job,
    output logic            full
);

    localparam int unsigned DEPTH = cprsm_pkg::JOB_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cprsm_pkg::job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en & ~full;
    assign do_rd    = rd_en & rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### hw/rtl/cprsm_divider.sv
// ============================================================================
// cprsm_divider: rounded quotient unit with result register
// Restoring division, one quotient bit per cycle, of (sum + ticks/2) by ticks.
// ============================================================================
module cprsm_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  cprsm_pkg::job_t job,
    output logic            job_pop,
    input  logic            out_pop,
    output logic            out_valid,
    output logic [cprsm_pkg::DATA_W-1:0] out_data
);

    localparam int unsigned DW = cprsm_pkg::DATA_W;
    localparam int unsigned SW = cprsm_pkg::STEP_W;

    cprsm_pkg::div_state_t state_reg, state_next;

    logic [DW:0]   num_reg, num_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          fits;
    logic          last_step;
    logic          zero_div;
    logic          result_load;

    always_comb
    begin
        shifted   = {rem_reg, num_reg[DW]};
        diff      = {1'b0, shifted} - {2'b00, div_reg};
        fits      = ~diff[DW+1];
        last_step = (step_reg == SW'(cprsm_pkg::DIV_STEPS - 1));
        zero_div  = (job.elapsed_ticks == '0);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cprsm_pkg::DIV_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = zero_div ? cprsm_pkg::DIV_DONE : cprsm_pkg::DIV_RUN;
                end
            end
            cprsm_pkg::DIV_RUN:
            begin
                if (last_step)
                begin
                    state_next = cprsm_pkg::DIV_DONE;
                end
            end
            cprsm_pkg::DIV_DONE:
            begin
                if (!out_valid_reg || out_pop)
                begin
                    state_next = cprsm_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = cprsm_pkg::DIV_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        job_pop     = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            cprsm_pkg::DIV_IDLE:
            begin
                job_pop = job_valid;
            end
            cprsm_pkg::DIV_RUN:
            begin
                job_pop = 1'b0;
            end
            cprsm_pkg::DIV_DONE:
            begin
                result_load = ~out_valid_reg | out_pop;
            end
            default:
            begin
                job_pop     = 1'b0;
                result_load = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        num_next       = num_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (job_pop)
        begin
            num_next  = {1'b0, job.pulse_sum} + {2'b00, job.elapsed_ticks[DW-1:1]};
            rem_next  = '0;
            div_next  = job.elapsed_ticks;
            quo_next  = zero_div ? {DW{1'b1}} : '0;
            step_next = '0;
        end
        else if (state_reg == cprsm_pkg::DIV_RUN)
        begin
            num_next  = {num_reg[DW-1:0], 1'b0};
            rem_next  = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            step_next = step_reg + 1'b1;
        end
        if (result_load)
        begin
            out_data_next  = quo_reg;
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cprsm_pkg::DIV_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/contact_pulse_rate_speed_meter_top.sv
// ============================================================================
// contact_pulse_rate_speed_meter_top: gated pulse rate speed meter
// Counts contact closures of a rotating sensor over a timed window and
// reports the rounded ratio of pulse sum to elapsed timer ticks.
// ============================================================================
//
// Each request on the input side is one sample of a free-running timer and
// of the sensor contact (0 closed). A falling contact edge opens a window;
// within it the wrapped timer differences build up the elapsed time and
// every further falling edge adds edge_step to the pulse sum. The window
// closes when the sum reaches sum_limit or the elapsed time exceeds
// window_ticks, and the sample that closes it yields one result request:
// (sum + elapsed/2) / elapsed, rounded down, or all ones when elapsed is
// zero. The front logic takes a sample whenever the job queue is not
// full, so samples may arrive back to back. A closing sample hands a
// divide job to a two-entry queue; the divider works one quotient bit per
// cycle and handles a job as a load, up to 33 steps and a hand-off into
// the result register, which sets the rate at which closed windows can
// be reported. full rises only when the job queue holds two unfinished
// divisions. Configuration registers take their writes at once and are
// meant to be changed only while no window result is pending.
//
module contact_pulse_rate_speed_meter_top #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Sample side.
    input  logic                           push,
    output logic                           full,
    input  logic [TIMER_BITS-1:0]          timer_value,
    input  logic                           contact_level,
    // Result side.
    output logic                           empty,
    input  logic                           pop,
    output logic [cprsm_pkg::DATA_W-1:0]   speed_value,
    // Configuration write port.
    input  logic                           cfg_write_en,
    input  logic [cprsm_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [cprsm_pkg::DATA_W-1:0]   cfg_data
);

    cprsm_pkg::cfg_t cfg_reg, cfg_next;

    logic            sample_accept;
    logic            front_job_valid;
    cprsm_pkg::job_t front_job;
    logic            queue_full;
    logic            queue_valid;
    cprsm_pkg::job_t queue_job;
    logic            queue_pop;
    logic            out_valid;

    // Configuration registers. An index past the last register is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                cprsm_pkg::REG_EDGE_STEP:    cfg_next.edge_step    = cfg_data;
                cprsm_pkg::REG_WINDOW_TICKS: cfg_next.window_ticks = cfg_data;
                cprsm_pkg::REG_SUM_LIMIT:    cfg_next.sum_limit    = cfg_data;
                default:                     cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_step    <= cprsm_pkg::EDGE_STEP_RESET;
            cfg_reg.window_ticks <= cprsm_pkg::WINDOW_TICKS_RESET;
            cfg_reg.sum_limit    <= cprsm_pkg::SUM_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A sample is taken whenever the job queue has room for a possible job.
    assign full          = queue_full;
    assign sample_accept = push & ~queue_full;

    cprsm_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_accept),
        .timer_value   (timer_value),
        .contact_level (contact_level),
        .cfg           (cfg_reg),
        .job_valid     (front_job_valid),
        .job           (front_job)
    );

    cprsm_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_job_valid),
        .wr_job   (front_job),
        .rd_en    (queue_pop),
        .rd_valid (queue_valid),
        .rd_job   (queue_job),
        .full     (queue_full)
    );

    cprsm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .out_pop   (pop),
        .out_valid (out_valid),
        .out_data  (speed_value)
    );

    assign empty = ~out_valid;

endmodule

### tb/cprsm_speed_checker.sv
// ============================================================================
// cprsm_speed_checker: result checker of the contact pulse rate speed meter
// Watches the sample, result and configuration ports, keeps its own model
// of the measurement window and compares every popped speed value with the
// oldest predicted one.
// ============================================================================
module cprsm_speed_checker #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic [TIMER_BITS-1:0]               timer_value,
    input  logic                                contact_level,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [cprsm_pkg::DATA_W-1:0]        speed_value,
    input  logic                                cfg_write_en,
    input  logic [cprsm_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [cprsm_pkg::DATA_W-1:0]        cfg_data,
    output int                                  mismatch_count,
    output int                                  pending_count,
    output int                                  checked_count
);

    localparam int unsigned DW = cprsm_pkg::DATA_W;

    cprsm_pkg::cfg_t       cfg_shadow;
    logic                  prev_level;
    logic [TIMER_BITS-1:0] ref_timer;
    logic                  window_open;
    logic [DW-1:0]         sum_acc;
    logic [DW-1:0]         ticks_acc;
    logic [DW-1:0]         speed_expected[$];

    // Rounded pulse rate; the numerator is formed at 33 bits so it cannot wrap.
    function automatic logic [DW-1:0] rounded_rate(input logic [DW-1:0] sum,
                                                   input logic [DW-1:0] ticks);
        logic [DW:0] num;
        if (ticks == '0)
            return '1;
        num = {1'b0, sum} + {2'b0, ticks[DW-1:1]};
        return DW'(num / {1'b0, ticks});
    endfunction

    // Advances the window model by one accepted sample.
    task automatic step_window(input logic [TIMER_BITS-1:0] now, input logic level);
        logic                  fell;
        logic                  closes;
        logic [TIMER_BITS-1:0] delta;
        logic [DW:0]           wide;
        fell       = prev_level && !level;
        closes     = 1'b0;
        prev_level = level;
        if (!window_open)
        begin
            if (fell)
            begin
                window_open = 1'b1;
                sum_acc     = '0;
                ticks_acc   = '0;
                ref_timer   = now;
            end
        end
        else
        begin
            delta     = now - ref_timer;
            wide      = {1'b0, ticks_acc} + (DW+1)'(delta);
            ticks_acc = wide[DW] ? '1 : wide[DW-1:0];
            ref_timer = now;
            if (fell)
            begin
                wide    = {1'b0, sum_acc} + {1'b0, cfg_shadow.edge_step};
                sum_acc = wide[DW] ? '1 : wide[DW-1:0];
                if (sum_acc >= cfg_shadow.sum_limit)
                    closes = 1'b1;
            end
            if (!closes && ticks_acc > cfg_shadow.window_ticks)
                closes = 1'b1;
            if (closes)
            begin
                speed_expected.push_back(rounded_rate(sum_acc, ticks_acc));
                window_open = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [DW-1:0] want;
        if (!rst_n)
        begin
            cfg_shadow.edge_step    = cprsm_pkg::EDGE_STEP_RESET;
            cfg_shadow.window_ticks = cprsm_pkg::WINDOW_TICKS_RESET;
            cfg_shadow.sum_limit    = cprsm_pkg::SUM_LIMIT_RESET;
            prev_level     = 1'b0;
            ref_timer      = '0;
            window_open    = 1'b0;
            sum_acc        = '0;
            ticks_acc      = '0;
            mismatch_count = 0;
            checked_count  = 0;
            speed_expected.delete();
        end
        else
        begin
            // Results are matched before the new sample is modeled, since a
            // closing sample can never produce its result in the same cycle.
            if (pop && !empty)
            begin
                if (speed_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected speed_value, expected none, actual 0x%08h",
                             $time, speed_value);
                end
                else
                begin
                    want = speed_expected.pop_front();
                    checked_count++;
                    if (speed_value !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: speed_value mismatch, expected 0x%08h, actual 0x%08h",
                                 $time, want, speed_value);
                    end
                end
            end
            // A sample taken at this edge still sees the old register values.
            if (push && !full)
                step_window(timer_value, contact_level);
            if (cfg_write_en)
            begin
                case (cfg_index)
                    cprsm_pkg::REG_EDGE_STEP:    cfg_shadow.edge_step    = cfg_data;
                    cprsm_pkg::REG_WINDOW_TICKS: cfg_shadow.window_ticks = cfg_data;
                    cprsm_pkg::REG_SUM_LIMIT:    cfg_shadow.sum_limit    = cfg_data;
                    default:                     ;
                endcase
            end
        end
        pending_count = speed_expected.size();
    end

endmodule

### tb/tb_contact_pulse_rate_speed_meter_top.sv
// ============================================================================
// tb_contact_pulse_rate_speed_meter_top: testbench of the speed meter
// Drives directed and random timer and contact samples against a stalling
// result reader, rewrites the window registers between phases and leaves
// all prediction and comparison to the checker instance.
// ============================================================================
module tb_contact_pulse_rate_speed_meter_top;

    localparam int unsigned TIMER_BITS   = 16;
    localparam int unsigned DW           = cprsm_pkg::DATA_W;
    localparam int unsigned IW           = cprsm_pkg::INDEX_W;
    // Far above the slowest legal run, in which every closed window waits
    // for the divider and then for the longest reader stalls.
    localparam int unsigned CYCLE_LIMIT  = 250000;
    // The divider takes one job at a time and the job queue holds two, so
    // this covers anything still in flight once the last result has left.
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned RAND_PHASES  = 9;
    localparam int unsigned PHASE_ITEMS  = 72;
    localparam int unsigned NUM_PROFILES = 6;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  push          = 1'b0;
    logic                  full;
    logic [TIMER_BITS-1:0] timer_value   = '0;
    logic                  contact_level = 1'b0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [DW-1:0]         speed_value;
    logic                  cfg_write_en  = 1'b0;
    logic [IW-1:0]         cfg_index     = '0;
    logic [DW-1:0]         cfg_data      = '0;

    int mismatch_count;
    int pending_count;
    int checked_count;

    int unsigned cycle_count   = 0;
    int unsigned samples_sent  = 0;
    int unsigned settings_used = 0;

    // Running timer of the sample source; it advances by a chosen delta
    // per sample and wraps like the free-running hardware timer.
    logic [TIMER_BITS-1:0] sim_timer = '0;

    // Reader behavior: a pop probability that is held for a random stretch.
    int unsigned pop_rate = 100;
    int unsigned pop_hold = 0;

    contact_pulse_rate_speed_meter_top #(
        .TIMER_BITS(TIMER_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .timer_value  (timer_value),
        .contact_level(contact_level),
        .empty        (empty),
        .pop          (pop),
        .speed_value  (speed_value),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cprsm_speed_checker #(
        .TIMER_BITS(TIMER_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .timer_value   (timer_value),
        .contact_level (contact_level),
        .empty         (empty),
        .pop           (pop),
        .speed_value   (speed_value),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a run that hangs on a lost result ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The result reader changes its pop probability now and then, from
    // always ready down to long stalls, so that full back-pressure builds
    // up through the job queue in some stretches and never in others.
    always @(negedge clk)
    begin
        if (pop_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0:       pop_rate <= 100;
                1:       pop_rate <= 60;
                2:       pop_rate <= 25;
                default: pop_rate <= 4;
            endcase
            pop_hold <= $urandom_range(20, 200);
        end
        else
        begin
            pop_hold <= pop_hold - 1;
        end
        pop <= rst_n && ($urandom_range(1, 100) <= pop_rate);
    end

    // Offers one sample request and returns at the falling edge after the
    // rising edge that took it. full only changes at a rising edge, so its
    // value at the falling edge tells whether the next edge accepts. push
    // is left high so that a following sample goes back to back.
    task automatic send_sample(input logic [TIMER_BITS-1:0] t, input logic lvl);
        push          <= 1'b1;
        timer_value   <= t;
        contact_level <= lvl;
        while (full)
            @(negedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    // Advances the source timer by delta ticks and sends the sample.
    task automatic send_step(input logic [TIMER_BITS-1:0] delta, input logic lvl);
        sim_timer = sim_timer + delta;
        send_sample(sim_timer, lvl);
    endtask

    // Idle gap on the sample side; the data lines carry noise meanwhile.
    task automatic pause(input int unsigned cycles);
        push          <= 1'b0;
        timer_value   <= TIMER_BITS'($urandom);
        contact_level <= 1'($urandom_range(0, 1));
        repeat (cycles) @(negedge clk);
    endtask

    // Holds the sample side until every predicted result has been read,
    // then gives the divider time to finish anything still under way.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [DW-1:0] step_val,
                                 input logic [DW-1:0] window_val,
                                 input logic [DW-1:0] limit_val);
        drain_results();
        write_reg(cprsm_pkg::REG_EDGE_STEP, step_val);
        write_reg(cprsm_pkg::REG_WINDOW_TICKS, window_val);
        write_reg(cprsm_pkg::REG_SUM_LIMIT, limit_val);
        settings_used++;
    endtask

    // Timer deltas from none at all up to one tick short of a full wrap of the timer.
    function automatic logic [TIMER_BITS-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:          return '0;
            1, 2, 3:    return TIMER_BITS'($urandom_range(1, 255));
            4, 5, 6, 7: return TIMER_BITS'($urandom_range(256, 65535));
            8:          return '1;
            default:    return TIMER_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned phase;
        int unsigned profile;
        int unsigned items;
        int unsigned burst;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. A step of all ones against a limit of one closes a
        // window on its first counted edge. Here that edge comes without
        // any timer movement, so the divisor is zero and the result must
        // saturate. The level then stays low to show that the closing edge
        // does not reopen a window. The next window opens at the top timer
        // value and wraps through zero, and its all-ones sum plus half of
        // the elapsed time overflows 32 bits in the rounding.
        apply_setting('1, '1, 32'd1);
        send_sample(16'd100, 1'b1);
        send_sample(16'd200, 1'b0);
        send_sample(16'd200, 1'b1);
        send_sample(16'd200, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b1);
        send_sample(16'd0, 1'b0);

        // Two steps above half scale saturate the pulse sum at all ones, which
        // meets the all-ones limit and closes the window.
        apply_setting(32'h9000_0000, 32'd1000, '1);
        send_sample(16'd10, 1'b1);
        send_sample(16'd20, 1'b0);
        send_sample(16'd30, 1'b1);
        send_sample(16'd40, 1'b0);
        send_sample(16'd50, 1'b1);
        send_sample(16'd60, 1'b0);

        // Smallest window: it closes by time as soon as two ticks have
        // passed, once with an empty sum and once after a counted edge.
        apply_setting(32'd1, 32'd1, '1);
        send_sample(16'd5, 1'b1);
        send_sample(16'd7, 1'b0);
        send_sample(16'd8, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd9, 1'b1);
        send_sample(16'd9, 1'b0);
        send_sample(16'd9, 1'b1);
        send_sample(16'd12, 1'b0);

        // Random part. The first phases walk through every register profile
        // once, the rest pick profiles at random. Each phase starts only
        // after all results of the previous one have been read.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            profile = (phase < NUM_PROFILES) ? phase : $urandom_range(0, NUM_PROFILES - 1);
            case (profile)
                0: apply_setting(cprsm_pkg::EDGE_STEP_RESET, cprsm_pkg::WINDOW_TICKS_RESET,
                                 cprsm_pkg::SUM_LIMIT_RESET);
                1: apply_setting(32'd1, 32'd1, 32'd1);
                2: apply_setting('1, $urandom_range(1, 200000), $urandom);
                3: apply_setting($urandom, $urandom >> $urandom_range(0, 20),
                                 $urandom >> $urandom_range(0, 4));
                4: apply_setting($urandom_range(1, 1000), $urandom_range(1, 5000), '1);
                default: apply_setting($urandom_range(32'h1000_0000, 32'hFFFF_FFFF), '1,
                                       $urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
            endcase
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    if (items < PHASE_ITEMS)
                    begin
                        // Now and then the timer jumps to an arbitrary value.
                        if ($urandom_range(0, 19) == 0)
                            sim_timer = TIMER_BITS'($urandom);
                        send_step(pick_delta(), 1'($urandom_range(0, 1)));
                        items++;
                    end
                end
                // A quarter of the bursts run straight into the next one.
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 10));
            end
        end

        drain_results();

        $display("Summary: %0d samples sent, %0d speed results checked, %0d register settings.",
                 samples_sent, checked_count, settings_used);
        $display("Covered zero divisor, saturated pulse sum, timer wrap and reader stalls.");
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### contact_pulse_rate_speed_meter_top.f
hw/rtl/cprsm_pkg.sv
hw/rtl/cprsm_front.sv
hw/rtl/cprsm_job_queue.sv
hw/rtl/cprsm_divider.sv
hw/rtl/contact_pulse_rate_speed_meter_top.sv
tb/cprsm_speed_checker.sv
tb/tb_contact_pulse_rate_speed_meter_top.sv
